[design/fingerprint_crop_window_top_defines.svh]
// ---------------------------------------------------------------------------
// fingerprint crop window assertion macros
// shared property wrappers, clocked on i_clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef FINGERPRINT_CROP_WINDOW_TOP_DEFINES_SVH
`define FINGERPRINT_CROP_WINDOW_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expression holds at every edge outside reset
`define FCW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

[design/fcw_pkg.sv]
// ---------------------------------------------------------------------------
// fcw_pkg
// types, constants and helper functions of the crop window finder
// ---------------------------------------------------------------------------
package fcw_pkg;

    localparam int MAX_DIM = 2048;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = IDX_W + 1;

    localparam int CFG_DIM_W = 12;
    localparam int LEVEL_W   = 8;
    localparam int PIX_W     = 8;
    localparam int OUT_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam int DIM_RESET  = 2048;
    localparam int DARK_RESET = 200;
    localparam int EDGE_RESET = 225;

    // trim bands: a span strictly inside (lo, lo + step) loses amount per side
    localparam int TRIM_LO    = 800;
    localparam int TRIM_HI    = 2000;
    localparam int TRIM_STEP  = 200;
    localparam int TRIM_UNIT  = 100;
    localparam int TRIM_BANDS = (TRIM_HI - TRIM_LO) / TRIM_STEP;
    localparam int TRIM_W     = $clog2(TRIM_BANDS * TRIM_UNIT + 1);
    localparam int SPAN_W     = OUT_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_DARK_LEVEL   = 2'd2,
        CFG_EDGE_LEVEL   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]   image_width;
        logic [CNT_W-1:0]   image_height;
        logic [LEVEL_W-1:0] dark_level;
        logic [LEVEL_W-1:0] edge_level;
    } t_cfg;

    // raw window of one frame before trimming
    typedef struct packed {
        logic [IDX_W-1:0] row_start;
        logic [CNT_W-1:0] row_end;
        logic [IDX_W-1:0] col_start;
        logic [IDX_W-1:0] col_end;
    } t_win;

    // span is a signed difference; a negative span is never trimmed
    function automatic logic [TRIM_W-1:0] f_trim(input logic [SPAN_W-1:0] span);
        logic [TRIM_W-1:0] amount;
        int                len;
        amount = '0;
        len    = int'(span[SPAN_W-2:0]);
        if (!span[SPAN_W-1]) begin
            for (int k = 0; k < TRIM_BANDS; k++) begin
                if (len > TRIM_LO + k * TRIM_STEP && len < TRIM_LO + (k + 1) * TRIM_STEP) begin
                    amount = TRIM_W'((k + 1) * TRIM_UNIT);
                end
            end
        end
        return amount;
    endfunction

endpackage

[design/fcw_cfg.sv]
// ---------------------------------------------------------------------------
// fcw_cfg
// configuration registers with write decode and frame size clamping
// ---------------------------------------------------------------------------
module fcw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fcw_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output fcw_pkg::t_cfg                 o_cfg
);
    import fcw_pkg::*;

    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;
    logic [LEVEL_W-1:0]   r_dark;
    logic [LEVEL_W-1:0]   r_edge_lvl;

    function automatic logic [CNT_W-1:0] f_clamp(input logic [CFG_DIM_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = CNT_W'(MAX_DIM);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_DIM_W'(DIM_RESET);
            r_height   <= CFG_DIM_W'(DIM_RESET);
            r_dark     <= LEVEL_W'(DARK_RESET);
            r_edge_lvl <= LEVEL_W'(EDGE_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width    <= CFG_DIM_W'(i_cfg_data);
                CFG_IMAGE_HEIGHT: r_height   <= CFG_DIM_W'(i_cfg_data);
                CFG_DARK_LEVEL:   r_dark     <= i_cfg_data[LEVEL_W-1:0];
                CFG_EDGE_LEVEL:   r_edge_lvl <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.image_width  = f_clamp(r_width);
        o_cfg.image_height = f_clamp(r_height);
        o_cfg.dark_level   = r_dark;
        o_cfg.edge_level   = r_edge_lvl;
    end

endmodule

[design/fcw_stats.sv]
// ---------------------------------------------------------------------------
// fcw_stats
// per-pixel row statistics, best row tracking and raw window register
// ---------------------------------------------------------------------------
`include "fingerprint_crop_window_top_defines.svh"

module fcw_stats (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fcw_pkg::t_cfg             i_cfg,
    input  logic                      i_pix_valid,
    output logic                      o_pix_stall,
    input  logic [fcw_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_win_valid,
    input  logic                      i_win_stall,
    output fcw_pkg::t_win             o_win
);
    import fcw_pkg::*;

    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_dark_cnt, n_dark_cnt;
    logic [IDX_W-1:0] r_first_edge, n_first_edge;
    logic [IDX_W-1:0] r_last_edge, n_last_edge;
    logic             r_edge_seen, n_edge_seen;
    logic [CNT_W-1:0] r_best_density, n_best_density;
    logic [IDX_W-1:0] r_best_first, n_best_first;
    logic [IDX_W-1:0] r_best_last, n_best_last;
    logic [IDX_W-1:0] r_best_rs, n_best_rs;
    logic [IDX_W-1:0] r_last_zero, n_last_zero;
    logic [IDX_W-1:0] r_zab, n_zab;
    logic             r_zs, n_zs;

    logic             r_win_valid;
    t_win             r_win;
    t_win             win;

    logic             win_load;
    logic             accept;
    logic             is_dark;
    logic             is_edge;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic             seen;
    logic             row_done;
    logic             frame_done;
    logic             upd;

    assign win_load    = !r_win_valid || !i_win_stall;
    assign o_pix_stall = !win_load;
    assign accept      = i_pix_valid && win_load;
    assign o_win_valid = r_win_valid;
    assign o_win       = r_win;

    always_comb begin
        is_dark    = i_pixel <= i_cfg.dark_level;
        is_edge    = i_pixel <= i_cfg.edge_level;
        cnt        = r_dark_cnt + CNT_W'(is_dark);
        first      = (is_edge && !r_edge_seen) ? r_col : r_first_edge;
        last       = is_edge ? r_col : r_last_edge;
        seen       = r_edge_seen | is_edge;
        row_done   = (CNT_W'(r_col) + CNT_W'(1)) >= i_cfg.image_width;
        frame_done = row_done && ((CNT_W'(r_row) + CNT_W'(1)) >= i_cfg.image_height);
        upd        = (r_row == '0) || (cnt > r_best_density);

        n_col          = r_col + IDX_W'(1);
        n_row          = r_row;
        n_dark_cnt     = cnt;
        n_first_edge   = first;
        n_last_edge    = last;
        n_edge_seen    = seen;
        n_best_density = r_best_density;
        n_best_first   = r_best_first;
        n_best_last    = r_best_last;
        n_best_rs      = r_best_rs;
        n_last_zero    = r_last_zero;
        n_zab          = r_zab;
        n_zs           = r_zs;

        if (row_done) begin
            n_col        = '0;
            n_dark_cnt   = '0;
            n_first_edge = '0;
            n_last_edge  = '0;
            n_edge_seen  = 1'b0;
            n_row        = r_row + IDX_W'(1);
            // first and last stay zero through a row without an edge
            if (upd) begin
                n_best_density = cnt;
                n_best_first   = first;
                n_best_last    = last;
                n_best_rs      = (r_row == '0) ? '0 : r_last_zero;
                n_zs           = 1'b0;
            end
            if (cnt == '0) begin
                n_last_zero = r_row;
                if (!n_zs) begin
                    n_zab = r_row;
                    n_zs  = 1'b1;
                end
            end
        end

        win.row_start = n_best_rs;
        win.row_end   = n_zs ? CNT_W'(n_zab) : i_cfg.image_height;
        win.col_start = n_best_first;
        win.col_end   = n_best_last;

        if (frame_done) begin
            n_row          = '0;
            n_best_density = '0;
            n_best_first   = '0;
            n_best_last    = '0;
            n_best_rs      = '0;
            n_last_zero    = '0;
            n_zab          = '0;
            n_zs           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_row          <= '0;
            r_dark_cnt     <= '0;
            r_first_edge   <= '0;
            r_last_edge    <= '0;
            r_edge_seen    <= 1'b0;
            r_best_density <= '0;
            r_best_first   <= '0;
            r_best_last    <= '0;
            r_best_rs      <= '0;
            r_last_zero    <= '0;
            r_zab          <= '0;
            r_zs           <= 1'b0;
            r_win_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_col          <= n_col;
                r_row          <= n_row;
                r_dark_cnt     <= n_dark_cnt;
                r_first_edge   <= n_first_edge;
                r_last_edge    <= n_last_edge;
                r_edge_seen    <= n_edge_seen;
                r_best_density <= n_best_density;
                r_best_first   <= n_best_first;
                r_best_last    <= n_best_last;
                r_best_rs      <= n_best_rs;
                r_last_zero    <= n_last_zero;
                r_zab          <= n_zab;
                r_zs           <= n_zs;
            end
            if (win_load) begin
                r_win_valid <= accept && frame_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_load && accept && frame_done) begin
            r_win <= win;
        end
    end

    `FCW_ASSERT_NEXT(a_frame_clears, accept && frame_done, r_row == '0 && r_col == '0,
        "counters not cleared after frame end")
    `FCW_ASSERT_ALWAYS(a_count_bound, r_dark_cnt <= CNT_W'(r_col),
        "row dark count exceeds pixels seen in row")
    `FCW_ASSERT_SAME(a_zero_after_order, r_zs, r_zab >= r_best_rs,
        "zero row after best lies before row start")
    `FCW_ASSERT_SAME(a_stall_needs_win, o_pix_stall, r_win_valid,
        "input stalled with empty window register")

endmodule

[design/fcw_trim.sv]
// ---------------------------------------------------------------------------
// fcw_trim
// band trimming of the raw window and the output register
// ---------------------------------------------------------------------------
`include "fingerprint_crop_window_top_defines.svh"

module fcw_trim (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_win_valid,
    output logic                      o_win_stall,
    input  fcw_pkg::t_win             i_win,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [fcw_pkg::OUT_W-1:0] o_row_start,
    output logic [fcw_pkg::OUT_W-1:0] o_row_end,
    output logic [fcw_pkg::OUT_W-1:0] o_col_start,
    output logic [fcw_pkg::OUT_W-1:0] o_col_end,
    output logic [fcw_pkg::OUT_W-1:0] o_crop_width,
    output logic [fcw_pkg::OUT_W-1:0] o_crop_height
);
    import fcw_pkg::*;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_row_start, n_row_start;
    logic [OUT_W-1:0]  r_row_end, n_row_end;
    logic [OUT_W-1:0]  r_col_start, n_col_start;
    logic [OUT_W-1:0]  r_col_end, n_col_end;
    logic [OUT_W-1:0]  r_crop_width, n_crop_width;
    logic [OUT_W-1:0]  r_crop_height, n_crop_height;

    logic              out_load;
    logic [OUT_W-1:0]  rs;
    logic [OUT_W-1:0]  re;
    logic [OUT_W-1:0]  cs;
    logic [OUT_W-1:0]  ce;
    logic [SPAN_W-1:0] col_span;
    logic [SPAN_W-1:0] row_span;
    logic [TRIM_W-1:0] col_trim;
    logic [TRIM_W-1:0] row_trim;

    assign out_load    = !r_out_valid || !i_out_stall;
    assign o_win_stall = !out_load;

    always_comb begin
        rs = OUT_W'(i_win.row_start);
        re = OUT_W'(i_win.row_end);
        cs = OUT_W'(i_win.col_start);
        ce = OUT_W'(i_win.col_end);
        // row span goes negative when the height shrank below the row start
        col_span = SPAN_W'(ce) - SPAN_W'(cs);
        row_span = SPAN_W'(re) - SPAN_W'(rs);
        col_trim = f_trim(col_span);
        row_trim = f_trim(row_span);

        n_col_start   = cs + OUT_W'(col_trim);
        n_col_end     = ce - OUT_W'(col_trim);
        n_row_start   = rs + OUT_W'(row_trim);
        n_row_end     = re - OUT_W'(row_trim);
        n_crop_width  = n_col_end - n_col_start;
        n_crop_height = n_row_end - n_row_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= i_win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && i_win_valid) begin
            r_row_start   <= n_row_start;
            r_row_end     <= n_row_end;
            r_col_start   <= n_col_start;
            r_col_end     <= n_col_end;
            r_crop_width  <= n_crop_width;
            r_crop_height <= n_crop_height;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_start   = r_row_start;
    assign o_row_end     = r_row_end;
    assign o_col_start   = r_col_start;
    assign o_col_end     = r_col_end;
    assign o_crop_width  = r_crop_width;
    assign o_crop_height = r_crop_height;

    `FCW_ASSERT_SAME(a_col_order, r_out_valid, r_col_end >= r_col_start,
        "trimmed column end before column start")
    `FCW_ASSERT_NEXT(a_win_taken, i_win_valid && !o_win_stall, r_out_valid,
        "window transaction lost in output register")
    `FCW_ASSERT_SAME(a_stall_needs_out, o_win_stall, r_out_valid,
        "window stalled with empty output register")

endmodule

[design/fingerprint_crop_window_top.sv]
// ---------------------------------------------------------------------------
// fingerprint_crop_window_top
// finds the crop window of a grayscale frame from row dark counts and edges
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  pix     | in        | i_pix_valid / o_pix_stall | i_pixel
//  out     | out       | o_out_valid / i_out_stall | o_row_start .. o_crop_height
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one pixel per cycle unless stalled; the window register loads with the
//  statistics on the edge that takes the last pixel of a frame, and the output
//  register holds the trimmed window. synchronous active-low reset clears counters
//  and statistics and loads register defaults. an output stall fills the output
//  register then the window register; pixels stall only when both hold a window.
// ---------------------------------------------------------------------------
module fingerprint_crop_window_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pix_valid,
    output logic                          o_pix_stall,
    input  logic [fcw_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fcw_pkg::OUT_W-1:0]     o_row_start,
    output logic [fcw_pkg::OUT_W-1:0]     o_row_end,
    output logic [fcw_pkg::OUT_W-1:0]     o_col_start,
    output logic [fcw_pkg::OUT_W-1:0]     o_col_end,
    output logic [fcw_pkg::OUT_W-1:0]     o_crop_width,
    output logic [fcw_pkg::OUT_W-1:0]     o_crop_height,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fcw_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import fcw_pkg::*;

    t_cfg cfg;
    t_win win;
    logic win_valid;
    logic win_stall;

    fcw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fcw_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_pixel     (i_pixel),
        .o_win_valid (win_valid),
        .i_win_stall (win_stall),
        .o_win       (win)
    );

    fcw_trim u_trim (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win_valid   (win_valid),
        .o_win_stall   (win_stall),
        .i_win         (win),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_start   (o_row_start),
        .o_row_end     (o_row_end),
        .o_col_start   (o_col_start),
        .o_col_end     (o_col_end),
        .o_crop_width  (o_crop_width),
        .o_crop_height (o_crop_height)
    );

endmodule
